// ----- design/mipv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipv_pkg: shared types and constants of the Merkle proof verifier
// SHA-256 round constants, initial hash value and controller/datapath links.
// ----------------------------------------------------------------------------
package mipv_pkg;

  localparam int unsigned HashW = 256;
  localparam int unsigned WordW = 64;
  localparam int unsigned InDataW = 448;  // 3*64 bounds + 256 hash, no gap
  localparam int unsigned OutDataW = 256;

  localparam logic CmdBegin = 1'b0;
  localparam logic CmdSibling = 1'b1;

  localparam logic [255:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Second message block: tail of right hash then fixed padding
  // byte 64 = last byte of right, byte 65 = 0x80, length 520 bits.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Commands from controller to datapath
  typedef struct packed {
    logic load_begin;   // capture leaf, bounds, flags
    logic load_sib;     // capture sibling, decide order
    logic skip_err;     // sibling with no levels left: set error
    logic blk_start;    // load message block into schedule, state from chain
    logic blk_second;   // 0 first block, 1 second block
    logic round_en;     // run one round
    logic blk_finish;   // add working vars into chain
    logic node_done;    // commit chain as running hash, shift positions
    logic proof_end;    // result taken: close the proof
  } mipv_cmd_t;

  typedef struct packed {
    logic error;        // sticky error flag
    logic active;       // proof open
    logic last_zero;    // last_position is zero
  } mipv_stat_t;

endpackage

// ----- design/mipv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipv_ctrl: sequencer of the Merkle proof verifier
// Accepts items, steps two 64-round compressions and hands out results.
// ----------------------------------------------------------------------------
module mipv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mipv_pkg::mipv_stat_t  stat_i,
  output mipv_pkg::mipv_cmd_t   cmd_o,
  output logic [5:0]            round_o
);

  typedef enum logic [2:0] {
    StIdle, StBlkLoad, StRound, StBlkAdd, StCommit, StOut
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] round_q, round_d;
  logic       second_q, second_d;
  logic       last_q, last_d;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign accept      = in_valid_i && in_ready_o;
  assign round_o     = round_q;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    second_d = second_q;
    last_d   = last_q;
    cmd_o    = '0;
    cmd_o.blk_second = second_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d = in_last_i;
          if (in_cmd_i == mipv_pkg::CmdBegin) begin
            cmd_o.load_begin = 1'b1;
            if (in_last_i) state_d = StOut;
          end else if (!stat_i.active) begin
            state_d = StIdle;
          end else if (stat_i.error) begin
            if (in_last_i) state_d = StOut;
          end else if (stat_i.last_zero) begin
            cmd_o.skip_err = 1'b1;
            if (in_last_i) state_d = StOut;
          end else begin
            cmd_o.load_sib = 1'b1;
            second_d = 1'b0;
            state_d  = StBlkLoad;
          end
        end
      end
      StBlkLoad: begin
        cmd_o.blk_start = 1'b1;
        round_d = '0;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) state_d = StBlkAdd;
      end
      StBlkAdd: begin
        cmd_o.blk_finish = 1'b1;
        if (second_q) begin
          state_d = StCommit;
        end else begin
          second_d = 1'b1;
          state_d  = StBlkLoad;
        end
      end
      StCommit: begin
        cmd_o.node_done = 1'b1;
        state_d = last_q ? StOut : StIdle;
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.proof_end = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      round_q  <= '0;
      second_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      round_q  <= round_d;
      second_q <= second_d;
      last_q   <= last_d;
    end
  end

endmodule

// ----- design/mipv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipv_datapath: hash state, position tracking and one SHA-256 round unit
// Keeps running and leaf hash, runs rounds on command, forms the result.
// ----------------------------------------------------------------------------
module mipv_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           leaf_index_i,
  input  logic [63:0]           subtree_start_i,
  input  logic [63:0]           subtree_end_i,
  input  logic [255:0]          hash_i,
  input  mipv_pkg::mipv_cmd_t   cmd_i,
  input  logic [5:0]            round_i,
  output mipv_pkg::mipv_stat_t  stat_o,
  output logic                  status_o,
  output logic [255:0]          root_o
);

  logic [255:0] run_q, leaf_q, sib_q, chain_q;
  logic [63:0]  pos_q, lastp_q;
  logic         err_q, act_q, sib_left_q;
  logic [31:0]  w_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

  // Subtree checks on begin
  logic [63:0] size, sm1, smear;
  logic        sub_ok, idx_ok;
  always_comb begin
    size  = subtree_end_i - subtree_start_i;
    sm1   = size - 64'd1;
    // alignment mask = next power of two at or above size, minus one
    smear = sm1;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 32);
    if (subtree_start_i >= subtree_end_i) sub_ok = 1'b0;
    else if (subtree_start_i == 64'd0) sub_ok = 1'b1;
    else if (size > (64'd1 << 63)) sub_ok = 1'b0;
    else sub_ok = ((subtree_start_i & smear) == 64'd0);
    idx_ok = (leaf_index_i >= subtree_start_i) && (leaf_index_i < subtree_end_i);
  end

  // Message blocks of 0x01 || left || right || padding
  logic [255:0] left, right;
  logic [511:0] blk0, blk1;
  assign left  = sib_left_q ? sib_q : run_q;
  assign right = sib_left_q ? run_q : sib_q;
  assign blk0  = {8'h01, left, right[255:8]};
  assign blk1  = {right[7:0], 8'h80, 480'h0, 16'h0208};

  // Trailing-zero shift count of position (plus the always-on one)
  logic [63:0] pos_sh, last_sh;
  always_comb begin
    pos_sh  = pos_q;
    last_sh = lastp_q;
    if (sib_left_q) begin
      // strip trailing zeros; position nonzero unless equal to last
      for (int i = 0; i < 64; i++) begin
        if (pos_q[i]) begin
          pos_sh  = pos_q >> i;
          last_sh = lastp_q >> i;
          break;
        end
      end
      if (pos_q == 64'd0) begin
        pos_sh  = 64'd0;
        last_sh = 64'd0;
      end
    end
  end

  // Round logic
  logic [31:0] s0, s1, wn, t1, t2, kk;
  always_comb begin
    s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    kk = mipv_pkg::round_k(round_i);
    t1 = h_q + ({e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]})
         + ((e_q & f_q) ^ (~e_q & g_q)) + kk + w_q[0];
    t2 = ({a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]})
         + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
  end

  // Control state: positions, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      leaf_q  <= '0;
      pos_q   <= '0;
      lastp_q <= '0;
      err_q   <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      if (cmd_i.load_begin) begin
        leaf_q  <= hash_i;
        run_q   <= hash_i;
        err_q   <= !sub_ok || !idx_ok;
        pos_q   <= leaf_index_i - subtree_start_i;
        lastp_q <= subtree_end_i - subtree_start_i - 64'd1;
        act_q   <= 1'b1;
      end
      if (cmd_i.skip_err) err_q <= 1'b1;
      if (cmd_i.node_done) begin
        run_q   <= chain_q;
        pos_q   <= pos_sh >> 1;
        lastp_q <= last_sh >> 1;
      end
      // drop the proof once its result is taken
      if (cmd_i.proof_end) act_q <= 1'b0;
    end
  end

  // Sibling capture and compression state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sib) begin
      sib_q      <= hash_i;
      sib_left_q <= pos_q[0] || (pos_q == lastp_q);
      chain_q    <= mipv_pkg::HashInit;
    end
    if (cmd_i.blk_start) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= cmd_i.blk_second ? blk1[511-32*i -: 32] : blk0[511-32*i -: 32];
      end
      {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= chain_q;
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end
    if (cmd_i.blk_finish) begin
      chain_q <= {chain_q[255:224] + a_q, chain_q[223:192] + b_q,
                  chain_q[191:160] + c_q, chain_q[159:128] + d_q,
                  chain_q[127:96] + e_q, chain_q[95:64] + f_q,
                  chain_q[63:32] + g_q, chain_q[31:0] + h_q};
    end
  end

  assign stat_o.error     = err_q;
  assign stat_o.active    = act_q;
  assign stat_o.last_zero = (lastp_q == 64'd0);

  // Result: leaf hash on any failure
  assign status_o = err_q || (lastp_q != 64'd0);
  assign root_o   = status_o ? leaf_q : run_q;

endmodule

// ----- design/merkle_inclusion_proof_verifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_inclusion_proof_verifier: top level
// Verifies a SHA-256 Merkle inclusion proof, one sibling item at a time.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_axis   in   tdata: leaf_index, subtree_start, subtree_end, hash_word0..3
//                tuser: command, tlast: last
//  m_axis   out  tdata: root_word0..3, tuser: status
//
// A hashed sibling runs from its accept through two 64-round compressions on
// a single round unit, each with a load and an add step, and a commit step.
// Begin items and skipped siblings are handled in their accept cycle. One
// item is in work at a time; the result waits in place until taken, and input
// is held off meanwhile. Reset clears all but sibling and compression regs.
module merkle_inclusion_proof_verifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] leaf_index, [127:64] subtree_start, [191:128] subtree_end,
  // [255:192] hash_word0 .. [447:384] hash_word3
  input  logic [447:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // command
  input  logic         s_axis_tlast,  // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] root_word0 .. [255:192] root_word3
  output logic [255:0] m_axis_tdata,
  output logic         m_axis_tuser   // status
);

  mipv_pkg::mipv_cmd_t  cmd;
  mipv_pkg::mipv_stat_t stat;
  logic [5:0]   round;
  logic [255:0] hash_in, root;

  assign hash_in = {s_axis_tdata[255:192], s_axis_tdata[319:256],
                    s_axis_tdata[383:320], s_axis_tdata[447:384]};
  assign m_axis_tdata = {root[63:0], root[127:64], root[191:128], root[255:192]};

  mipv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .round_o    (round)
  );

  mipv_datapath u_dp (
    .clk_i, .rst_ni,
    .leaf_index_i   (s_axis_tdata[63:0]),
    .subtree_start_i(s_axis_tdata[127:64]),
    .subtree_end_i  (s_axis_tdata[191:128]),
    .hash_i         (hash_in),
    .cmd_i          (cmd),
    .round_i        (round),
    .stat_o         (stat),
    .status_o       (m_axis_tuser),
    .root_o         (root)
  );

endmodule

// ----- design/mipv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipv_assert: port-level checks of the Merkle proof verifier
// Watches handshakes and result stability over time.
// ----------------------------------------------------------------------------
module mipv_assert (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // Never take input while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser)) else $error("result changed under stall");

  // Result drops after it is taken
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("result repeated");

  // If input was ready right before a result's first cycle, an item was accepted then
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) || $past(s_axis_tvalid))
    else $error("result without cause");

endmodule

bind merkle_inclusion_proof_verifier mipv_assert u_mipv_assert (.*);
